// ===== src/hll_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helper functions for the hyperloglog register update block
// no dependencies

package hll_pkg;

  localparam int MaxPrecision = 14;
  localparam int MinPrecision = 4;
  localparam int AddrW        = MaxPrecision;
  localparam int RegDepth     = 2 ** MaxPrecision;
  localparam int RankW        = 6;
  localparam int CountW       = 48;
  localparam int HashW        = 64;
  localparam int PrecW        = 4;
  localparam int ModeW        = 3;

  typedef enum logic [ModeW-1:0] {
    MODE_ADD      = 3'd0,
    MODE_MERGE    = 3'd1,
    MODE_MTOTAL   = 3'd2,
    MODE_READ     = 3'd3,
    MODE_CLEAR    = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_INIT  = 3'b001,
    ST_RUN   = 3'b010,
    ST_CLEAR = 3'b100
  } state_e;

  // clamp the programmed precision into the supported range
  function automatic logic [PrecW-1:0] eff_prec(logic [PrecW-1:0] p);
    logic [PrecW-1:0] r;
    r = p;
    if (p < PrecW'(MinPrecision)) r = PrecW'(MinPrecision);
    if (p > PrecW'(MaxPrecision)) r = PrecW'(MaxPrecision);
    return r;
  endfunction

  // leading zero count of a 64-bit word, 64 when zero
  function automatic logic [6:0] lzc64(logic [HashW-1:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < HashW; i++) begin
      if (v[i]) n = 7'(HashW - 1 - i);
    end
    return n;
  endfunction

endpackage

// ===== src/hll_ram.sv =====
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module hll_ram #(
  parameter int Width = 6,
  parameter int Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/hll_sketch_register_update.sv =====
`timescale 1ns / 1ps
// an item's ram read and update-stage load happen at its accept edge; its result moves into
//   the output register when the update stage advances, which output back-pressure can hold
// throughput: one item per cycle for add, merge, merge total and read unless the output
//   stalls, set by the single read-modify-write pass over the register ram with write-to-read forwarding
// clear stalls the input while the sweep starts and then while it zeroes the 2^p ram entries
// reset: counters and handshakes clear at once; a clearing pass then zeroes all 16384 ram
//   entries while in_ready_o stays low (config writes are still taken)
// depends on hll_pkg and hll_ram

module hll_sketch_register_update (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hll_pkg::PrecW-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [hll_pkg::ModeW-1:0]  mode_i,
  input  logic [hll_pkg::HashW-1:0]  hash_i,
  input  logic [hll_pkg::AddrW-1:0]  reg_index_i,
  input  logic [hll_pkg::RankW-1:0]  reg_value_i,
  input  logic [hll_pkg::CountW-1:0] merge_total_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [hll_pkg::RankW-1:0]  read_value_o,
  output logic                       raised_o,
  output logic [hll_pkg::CountW-1:0] items_total_o
);

  import hll_pkg::*;

  // configuration and derived masks
  logic [PrecW-1:0] prec_q;
  logic [PrecW-1:0] p_eff;
  logic [AddrW:0]   nregs;
  logic [AddrW-1:0] idx_mask;

  // sequencer
  state_e           state_q, state_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic             clr_done_q, clr_done_d;

  // update stage
  logic              b_valid_q;
  mode_e             b_mode_q;
  logic [AddrW-1:0]  b_addr_q;
  logic [RankW-1:0]  b_val_q;
  logic [CountW-1:0] b_total_q;
  logic              fwd_hit_q;
  logic [RankW-1:0]  fwd_data_q;
  logic [CountW-1:0] count_q;

  // output register
  logic              out_valid_q;
  logic [RankW-1:0]  read_value_q;
  logic              raised_q;
  logic [CountW-1:0] items_total_q;

  // accept-side decode
  logic              accept;
  mode_e             in_mode;
  logic [HashW-1:0]  rest;
  logic [6:0]        lz;
  logic [RankW-1:0]  rank;
  logic [AddrW-1:0]  hidx;
  logic [AddrW-1:0]  a_addr;
  logic [RankW-1:0]  a_val;
  logic [CountW-1:0] a_total;

  // update-side logic
  logic              b_adv;
  logic              b_is_clear;
  logic [RankW-1:0]  rdata;
  logic [RankW-1:0]  cur;
  logic              raise;
  logic [RankW-1:0]  rd_val;
  logic [CountW:0]   sum;
  logic [CountW-1:0] count_new;

  // ram ports
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [RankW-1:0] ram_wdata;

  assign p_eff    = eff_prec(prec_q);
  assign nregs    = (AddrW+1)'(1) << p_eff;
  assign idx_mask = AddrW'(nregs - (AddrW+1)'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prec_q <= PrecW'(MaxPrecision);
    end else if (cfg_we_i) begin
      prec_q <= cfg_data_i;
    end
  end

  // item decode in the accept cycle
  assign in_mode = mode_e'(mode_i);
  assign rest    = (hash_i << p_eff) | (HashW'(1) << (p_eff - PrecW'(1)));
  assign lz      = lzc64(rest);
  assign rank    = RankW'(lz + 7'd1);
  assign hidx    = AddrW'(hash_i >> (7'd64 - {3'b000, p_eff})) & idx_mask;

  always_comb begin
    a_addr  = reg_index_i & idx_mask;
    a_val   = reg_value_i;
    a_total = merge_total_i;
    if (in_mode == MODE_ADD) begin
      a_addr  = hidx;
      a_val   = rank;
      a_total = CountW'(1);
    end
  end

  assign b_is_clear = (b_mode_q == MODE_CLEAR);
  assign b_adv      = b_valid_q && (!out_valid_q || out_ready_i) &&
                      !(b_is_clear && !clr_done_q);
  assign in_ready_o = (state_q == ST_RUN) && (!b_valid_q || b_adv);
  assign accept     = in_valid_i && in_ready_o;

  // read-modify-write
  assign cur = fwd_hit_q ? fwd_data_q : rdata;

  always_comb begin
    raise     = 1'b0;
    rd_val    = '0;
    sum       = {1'b0, count_q} + {1'b0, b_total_q};
    count_new = count_q;
    case (b_mode_q)
      MODE_ADD: begin
        raise     = (b_val_q > cur);
        count_new = sum[CountW] ? '1 : sum[CountW-1:0];
      end
      MODE_MERGE: begin
        raise = (b_val_q > cur);
      end
      MODE_MTOTAL: begin
        count_new = sum[CountW] ? '1 : sum[CountW-1:0];
      end
      MODE_READ: begin
        rd_val = cur;
      end
      MODE_CLEAR: begin
        count_new = '0;
      end
      default: begin
        count_new = count_q;
      end
    endcase
  end

  // write port: sweep during init and clear, update otherwise
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = b_addr_q;
    ram_wdata = b_val_q;
    if (state_q == ST_INIT || state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (b_adv && raise) begin
      ram_we = 1'b1;
    end
  end

  hll_ram #(
    .Width (RankW),
    .Depth (RegDepth)
  ) u_regs (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (a_addr),
    .rdata_o (rdata)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    clr_done_d = clr_done_q;
    case (state_q)
      ST_INIT: begin
        clr_cnt_d = clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == '1) begin
          state_d   = ST_RUN;
          clr_cnt_d = '0;
        end
      end
      ST_RUN: begin
        if (b_adv) begin
          clr_done_d = 1'b0;
        end else if (b_valid_q && b_is_clear && !clr_done_q) begin
          state_d   = ST_CLEAR;
          clr_cnt_d = '0;
        end
      end
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == idx_mask) begin
          state_d    = ST_RUN;
          clr_cnt_d  = '0;
          clr_done_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_cnt_q   <= '0;
      clr_done_q  <= 1'b0;
      b_valid_q   <= 1'b0;
      fwd_hit_q   <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      clr_done_q <= clr_done_d;
      if (accept) begin
        b_valid_q <= 1'b1;
        // the read at this edge misses the write that lands at the same edge
        fwd_hit_q <= ram_we && (ram_waddr == a_addr);
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
        fwd_hit_q <= 1'b0;
      end
      if (b_adv) begin
        count_q <= count_new;
      end
      if (b_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_mode_q   <= in_mode;
      b_addr_q   <= a_addr;
      b_val_q    <= a_val;
      b_total_q  <= a_total;
      fwd_data_q <= ram_wdata;
    end
    if (b_adv) begin
      read_value_q  <= rd_val;
      raised_q      <= raise;
      items_total_q <= count_new;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = read_value_q;
  assign raised_o      = raised_q;
  assign items_total_o = items_total_q;

  // forwarded data only ever belongs to an item held in the update stage
  a_fwd_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> b_valid_q)
    else $error("forward hit without an item in the update stage");

  // no new item while a clear is still sweeping
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_is_clear && !clr_done_q) |-> !in_ready_o)
    else $error("item accepted during clear sweep");

  // the sweep ends only by marking the clear done
  a_clear_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> (state_q == ST_CLEAR) || clr_done_q)
    else $error("clear sweep left without completion");

  // an add always leaves a nonzero count behind
  a_add_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_adv && b_mode_q == MODE_ADD) |=> (count_q != '0))
    else $error("add did not advance the item count");

endmodule
